### rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative cache lookup with LRU
// replacement: register indexes, defaults, sequencer states, scan structs.
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int DEF_MAX_SETS     = 1024;
   localparam int DEF_WAYS         = 8;
   localparam int DEF_ADDRESS_BITS = 32;

   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int AGE_W     = 3;
   localparam int WAY_OUT_W = 3;
   localparam int COUNT_W   = 32;

   localparam logic [AGE_W-1:0] AGE_MAX   = 3'd7;
   localparam logic [CFG_W-1:0] SHIFT_MIN = 4'd2;
   localparam logic [CFG_W-1:0] SHIFT_MAX = 4'd9;

   localparam logic [CFG_W-1:0] RST_OFFSET_SHIFT   = 4'd6;
   localparam logic [CFG_W-1:0] RST_SET_INDEX_BITS = 4'd7;
   localparam logic [CFG_W-1:0] RST_WAYS_IN_USE    = 4'd1;
   localparam logic             RST_WRITE_BACK     = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_SHIFT,
      CSR_SET_INDEX_BITS,
      CSR_WAYS_IN_USE,
      CSR_WRITE_BACK
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_UPDATE,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic             hit;
      logic             has_invalid;
      logic [AGE_W-1:0] oldest_age;
   } scan_flags_type;

endpackage

### rtl/sacl_ifs.sv
// ----------------------------------------------------------------------------
// sacl channel interfaces
// Valid/ready channels for access requests, lookup responses and register
// writes.
// ----------------------------------------------------------------------------
interface sacl_req_if #(parameter int ADDRESS_BITS = sacl_pkg::DEF_ADDRESS_BITS);
   logic                    valid;
   logic                    ready;
   logic [ADDRESS_BITS-1:0] address;
   logic                    action;

   modport source (output valid, address, action, input ready);
   modport sink   (input valid, address, action, output ready);
endinterface

interface sacl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic [sacl_pkg::WAY_OUT_W-1:0]     way;
   logic [sacl_pkg::COUNT_W-1:0]       total_hits;
   logic [sacl_pkg::COUNT_W-1:0]       total_misses;

   modport source (output valid, hit, way, total_hits, total_misses, input ready);
   modport sink   (input valid, hit, way, total_hits, total_misses, output ready);
endinterface

interface sacl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sacl_pkg::CSR_IDX_W-1:0] index;
   logic [sacl_pkg::CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sacl_way_scan.sv
// ----------------------------------------------------------------------------
// sacl_way_scan
// Shared tag compare unit: walks the ways of one set, one way a beat of the
// sequencer, and tracks first hit, first invalid way and oldest way.
// ----------------------------------------------------------------------------
module sacl_way_scan #(
   parameter int WAY_W = 3,
   parameter int TAG_W = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sacl_pkg::scan_ctl_type        ctl,
   input  logic [WAY_W-1:0]              idx,
   input  logic                          ent_valid,
   input  logic [sacl_pkg::AGE_W-1:0]    ent_age,
   input  logic [TAG_W-1:0]              ent_tag,
   input  logic [TAG_W-1:0]              line,
   output sacl_pkg::scan_flags_type      flags,
   output logic [WAY_W-1:0]              hit_way,
   output logic [WAY_W-1:0]              inv_way,
   output logic [WAY_W-1:0]              old_way
);
   import sacl_pkg::*;

   scan_flags_type   flags_ff, flags_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [WAY_W-1:0] inv_way_ff, inv_way_in;
   logic [WAY_W-1:0] old_way_ff, old_way_in;
   logic             match;

   assign match = ent_valid && (ent_tag == line);

   always_comb begin
      flags_in   = flags_ff;
      hit_way_in = hit_way_ff;
      inv_way_in = inv_way_ff;
      old_way_in = old_way_ff;
      if (ctl.start) begin
         flags_in.hit         = match;
         flags_in.has_invalid = !ent_valid;
         flags_in.oldest_age  = ent_age;
         hit_way_in           = idx;
         inv_way_in           = idx;
         old_way_in           = idx;
      end else if (ctl.step) begin
         if (!flags_ff.hit && match) begin
            flags_in.hit = 1'b1;
            hit_way_in   = idx;
         end
         if (!flags_ff.has_invalid && !ent_valid) begin
            flags_in.has_invalid = 1'b1;
            inv_way_in           = idx;
         end
         if (ent_age > flags_ff.oldest_age) begin
            flags_in.oldest_age = ent_age;
            old_way_in          = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      hit_way_ff <= hit_way_in;
      inv_way_ff <= inv_way_in;
      old_way_ff <= old_way_in;
   end

   assign flags   = flags_ff;
   assign hit_way = hit_way_ff;
   assign inv_way = inv_way_ff;
   assign old_way = old_way_ff;

endmodule

### rtl/set_associative_cache_lookup_lru_top.sv
// ----------------------------------------------------------------------------
// set_associative_cache_lookup_lru_top
// Tag-only set-associative cache lookup with true LRU replacement.
// Flow: an accepted access has its tag row read, then the shared compare unit
// visits one way per cycle, and the row is updated and written back.
// A new access is taken only in idle, after the write-back, which waits while the previous response is still held.
// Reset: synchronous; a clearing pass then zeroes one set row per cycle over
// all MAX_SETS rows, during which no access is taken (register writes are).
// ----------------------------------------------------------------------------
module set_associative_cache_lookup_lru_top #(
   parameter int MAX_SETS     = sacl_pkg::DEF_MAX_SETS,
   parameter int WAYS         = sacl_pkg::DEF_WAYS,
   parameter int ADDRESS_BITS = sacl_pkg::DEF_ADDRESS_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sacl_req_if.sink   req_if,
   sacl_rsp_if.source rsp_if,
   sacl_csr_if.sink   csr_if
);
   import sacl_pkg::*;

   localparam int SET_BITS = $clog2(MAX_SETS);
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NW_W     = WAY_W + 1;
   localparam int TAG_W    = ADDRESS_BITS - 2;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [AGE_W-1:0] age;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   row_type mem [MAX_SETS];

   state_type state_ff, state_in;

   logic [CFG_W-1:0] offset_shift_ff, set_bits_ff, ways_ff;
   logic             write_back_ff;

   logic [CFG_W-1:0] sh_eff;
   logic [CFG_W:0]   sb_eff;
   logic [NW_W-1:0]  nways;
   logic [SET_W-1:0] set_mask;
   logic [ADDRESS_BITS-1:0] req_addr;

   logic [SET_W-1:0] clr_idx_ff;
   logic [WAY_W-1:0] scan_idx_ff;
   logic [TAG_W-1:0] line_ff;
   logic [SET_W-1:0] set_ff;
   logic             dirty_now_ff;

   row_type          rd_data_ff;
   row_type          row_ff, row_in;
   logic             hit_ff;
   logic [WAY_W-1:0] way_ff, chosen;

   logic [COUNT_W-1:0] hit_cnt_ff, miss_cnt_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;
   logic [COUNT_W-1:0] rsp_hits_ff, rsp_misses_ff;

   logic             req_fire, csr_fire, rsp_free;
   logic             mem_we, mem_re;
   logic [SET_W-1:0] mem_waddr;
   row_type          mem_wdata;

   scan_ctl_type     scan_ctl;
   scan_flags_type   flags;
   logic [WAY_W-1:0] hit_way, inv_way, old_way;
   entry_type        scan_ent;
   logic [AGE_W:0]   old_age;

   // ---------------------------------------------------------------- config
   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_shift_ff <= RST_OFFSET_SHIFT;
         set_bits_ff     <= RST_SET_INDEX_BITS;
         ways_ff         <= RST_WAYS_IN_USE;
         write_back_ff   <= RST_WRITE_BACK;
      end else if (csr_fire) begin
         case (csr_index_type'(csr_if.index))
            CSR_OFFSET_SHIFT:   offset_shift_ff <= csr_if.data;
            CSR_SET_INDEX_BITS: set_bits_ff     <= csr_if.data;
            CSR_WAYS_IN_USE:    ways_ff         <= csr_if.data;
            CSR_WRITE_BACK:     write_back_ff   <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (offset_shift_ff < SHIFT_MIN) begin
         sh_eff = SHIFT_MIN;
      end else if (offset_shift_ff > SHIFT_MAX) begin
         sh_eff = SHIFT_MAX;
      end else begin
         sh_eff = offset_shift_ff;
      end
      if (int'(set_bits_ff) > SET_BITS) begin
         sb_eff = (CFG_W+1)'(SET_BITS);
      end else begin
         sb_eff = {1'b0, set_bits_ff};
      end
      if (ways_ff == '0) begin
         nways = NW_W'(1);
      end else if (int'(ways_ff) > WAYS) begin
         nways = NW_W'(WAYS);
      end else begin
         nways = NW_W'(ways_ff);
      end
   end

   assign set_mask = (SET_BITS == 0) ? '0 : ~({SET_W{1'b1}} << sb_eff);
   assign req_addr = ADDRESS_BITS'(req_if.address);

   // ------------------------------------------------------------- sequencer
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_idx_ff == SET_W'(MAX_SETS - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire) state_in = ST_READ;
         ST_READ:   state_in = ST_SCAN;
         ST_SCAN:   if ({1'b0, scan_idx_ff} == nways - 1'b1) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_WRITE;
         ST_WRITE:  if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready   = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = set_ff;
      mem_wdata      = row_ff;
      scan_ctl.start = 1'b0;
      scan_ctl.step  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
         end
         ST_IDLE:  req_if.ready = 1'b1;
         ST_READ:  mem_re = 1'b1;
         ST_SCAN: begin
            scan_ctl.start = (scan_idx_ff == '0);
            scan_ctl.step  = 1'b1;
         end
         ST_WRITE: mem_we = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_idx_ff  <= '0;
         scan_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         if (state_ff == ST_READ) begin
            scan_idx_ff <= '0;
         end else if (state_ff == ST_SCAN) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ tag store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[set_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_ff      <= TAG_W'(req_addr >> sh_eff);
         set_ff       <= SET_W'(req_addr >> sh_eff) & set_mask;
         dirty_now_ff <= req_if.action && write_back_ff;
      end
   end

   // ----------------------------------------------------------- way scan
   assign scan_ent = rd_data_ff[scan_idx_ff];

   sacl_way_scan #(
      .WAY_W (WAY_W),
      .TAG_W (TAG_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .idx       (scan_idx_ff),
      .ent_valid (scan_ent.valid),
      .ent_age   (scan_ent.age),
      .ent_tag   (scan_ent.tag),
      .line      (line_ff),
      .flags     (flags),
      .hit_way   (hit_way),
      .inv_way   (inv_way),
      .old_way   (old_way)
   );

   // --------------------------------------------------------- row update
   always_comb begin
      if (flags.hit) begin
         chosen  = hit_way;
         old_age = {1'b0, rd_data_ff[hit_way].age};
      end else if (flags.has_invalid) begin
         chosen  = inv_way;
         old_age = {1'b0, AGE_MAX} + 1'b1;
      end else begin
         chosen  = old_way;
         old_age = {1'b0, flags.oldest_age};
      end
   end

   always_comb begin
      row_in = rd_data_ff;
      for (int v = 0; v < WAYS; v++) begin
         if (WAY_W'(v) == chosen) begin
            row_in[v].valid = 1'b1;
            row_in[v].age   = '0;
            if (flags.hit) begin
               row_in[v].dirty = rd_data_ff[v].dirty || dirty_now_ff;
            end else begin
               row_in[v].dirty = dirty_now_ff;
               row_in[v].tag   = line_ff;
            end
         end else if (v < int'(nways) && rd_data_ff[v].valid &&
                      {1'b0, rd_data_ff[v].age} < old_age &&
                      rd_data_ff[v].age < AGE_MAX) begin
            row_in[v].age = rd_data_ff[v].age + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         row_ff <= row_in;
         hit_ff <= flags.hit;
         way_ff <= chosen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         if (flags.hit) begin
            if (hit_cnt_ff != '1) hit_cnt_ff <= hit_cnt_ff + 1'b1;
         end else begin
            if (miss_cnt_ff != '1) miss_cnt_ff <= miss_cnt_ff + 1'b1;
         end
      end
   end

   // -------------------------------------------------------- response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_WRITE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_WRITE && rsp_free) begin
         rsp_hit_ff    <= hit_ff;
         rsp_way_ff    <= WAY_OUT_W'(way_ff);
         rsp_hits_ff   <= hit_cnt_ff;
         rsp_misses_ff <= miss_cnt_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.way          = rsp_way_ff;
   assign rsp_if.total_hits   = rsp_hits_ff;
   assign rsp_if.total_misses = rsp_misses_ff;

   // ------------------------------------------------------------ checks
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_READ)
      else $error("accepted beat did not start a tag read");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> {1'b0, scan_idx_ff} < nways)
      else $error("way scan ran past the ways in use");

   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hit_cnt_ff >= $past(hit_cnt_ff))
      else $error("hit total decreased");

   a_misses_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> miss_cnt_ff >= $past(miss_cnt_ff))
      else $error("miss total decreased");

endmodule

### sim/set_associative_cache_lookup_lru_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_associative_cache_lookup_lru_top_tb
// Self-checking bench for the tag-only set-associative lookup with LRU
// replacement. A queue-fed driver offers accesses, and a shadow tag store with
// its own age bookkeeping predicts hit, way and the running totals of every
// accepted beat. A monitor compares each response beat field by field against
// the oldest prediction. Directed accesses cover address and register extremes,
// including clamped register values, invalid-way fills and LRU eviction.
// Random phases then sweep register settings with a small working set per set,
// mixed with unrelated addresses. Both sides idle at random, and the response
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module set_associative_cache_lookup_lru_top_tb;
   import sacl_pkg::*;

   localparam int          WAYS          = DEF_WAYS;
   localparam int          MAX_SET_BITS  = $clog2(DEF_MAX_SETS);
   localparam int          ENTRIES       = DEF_MAX_SETS * DEF_WAYS;
   localparam logic        ACT_READ      = 1'b0;
   localparam logic        ACT_WRITE     = 1'b1;
   localparam int          IDLE_PCT      = 7;
   localparam int          WILD_PCT      = 15;
   localparam int          PHASE_BEATS   = 50;
   localparam int          RANDOM_PHASES = 8;
   localparam int          STALL_AT      = 60;
   localparam int          STALL_CYCLES  = 300;
   localparam int          DRAIN_CYCLES  = 24;
   localparam logic [31:0] COUNT_LIMIT   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [DEF_ADDRESS_BITS-1:0] address;
      logic                        action;
   } access_type;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic [COUNT_W-1:0]   total_hits;
      logic [COUNT_W-1:0]   total_misses;
   } lookup_type;

   logic clock;
   logic reset;

   sacl_req_if req_if ();
   sacl_rsp_if rsp_if ();
   sacl_csr_if csr_if ();

   set_associative_cache_lookup_lru_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // shadow register file
   logic [CFG_W-1:0] cfg_offset_shift;
   logic [CFG_W-1:0] cfg_set_bits;
   logic [CFG_W-1:0] cfg_ways;
   logic             cfg_write_back;

   // shadow tag store
   bit               line_valid [ENTRIES];
   bit               line_dirty [ENTRIES];
   logic [31:0]      line_tag   [ENTRIES];
   logic [AGE_W-1:0] line_age   [ENTRIES];
   logic [31:0]      hit_total;
   logic [31:0]      miss_total;

   access_type  access_q [$];
   lookup_type  lookup_q [$];
   access_type  offered;
   lookup_type  want;
   logic [31:0] tag_base;

   int errors;
   int accesses_sent;
   int lookups_seen;
   int hits_seen;
   int settings_used;
   int stall_left;
   bit stall_done;

   function automatic int unsigned eff_shift();
      if (cfg_offset_shift < SHIFT_MIN) return int'(SHIFT_MIN);
      if (cfg_offset_shift > SHIFT_MAX) return int'(SHIFT_MAX);
      return int'(cfg_offset_shift);
   endfunction

   function automatic int unsigned eff_set_bits();
      return (int'(cfg_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
   endfunction

   function automatic int unsigned eff_ways();
      if (cfg_ways == '0) return 1;
      return (int'(cfg_ways) > WAYS) ? WAYS : int'(cfg_ways);
   endfunction

   function automatic void touch_way(int unsigned base, int unsigned w, int unsigned nw,
                                     bit was_valid);
      int unsigned old_age;
      int unsigned v;
      old_age = was_valid ? int'(line_age[base + w]) : int'(AGE_MAX) + 1;
      for (v = 0; v < nw; v++) begin
         if (v != w && line_valid[base + v] && line_age[base + v] < old_age &&
             line_age[base + v] < AGE_MAX)
            line_age[base + v] = line_age[base + v] + 1'b1;
      end
      line_age[base + w] = '0;
   endfunction

   function automatic lookup_type predict_lookup(access_type acc);
      int unsigned      sh;
      int unsigned      nw;
      int unsigned      base;
      int unsigned      w;
      int unsigned      victim;
      logic [31:0]      line;
      logic [AGE_W-1:0] oldest;
      bit               hit;
      bit               have_invalid;
      bit               dirty_now;
      lookup_type       res;
      sh           = eff_shift();
      nw           = eff_ways();
      line         = acc.address >> sh;
      base         = (line & ((32'd1 << eff_set_bits()) - 1)) * WAYS;
      hit          = 1'b0;
      have_invalid = 1'b0;
      victim       = 0;
      oldest       = '0;
      dirty_now    = (acc.action == ACT_WRITE) && cfg_write_back;
      for (w = 0; w < nw; w++) begin
         if (!hit && line_valid[base + w] && line_tag[base + w] == line) begin
            hit    = 1'b1;
            victim = w;
         end
      end
      if (hit) begin
         if (hit_total != COUNT_LIMIT) hit_total++;
         touch_way(base, victim, nw, 1'b1);
         if (dirty_now) line_dirty[base + victim] = 1'b1;
      end else begin
         if (miss_total != COUNT_LIMIT) miss_total++;
         for (w = 0; w < nw; w++) begin
            if (!have_invalid && !line_valid[base + w]) begin
               victim       = w;
               have_invalid = 1'b1;
            end
         end
         if (!have_invalid) begin
            for (w = 0; w < nw; w++) begin
               if (w == 0 || line_age[base + w] > oldest) begin
                  oldest = line_age[base + w];
                  victim = w;
               end
            end
         end
         touch_way(base, victim, nw, !have_invalid);
         line_valid[base + victim] = 1'b1;
         line_tag[base + victim]   = line;
         line_dirty[base + victim] = dirty_now;
      end
      res.hit          = hit;
      res.way          = victim[WAY_OUT_W-1:0];
      res.total_hits   = hit_total;
      res.total_misses = miss_total;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   task automatic queue_access(logic [31:0] address, logic action);
      access_type acc;
      acc.address = address;
      acc.action  = action;
      access_q.push_back(acc);
   endtask

   task automatic queue_random_access();
      access_type  acc;
      int unsigned sh;
      int unsigned sb;
      int unsigned span;
      sh   = eff_shift();
      sb   = eff_set_bits();
      span = (sb > 2) ? 4 : (1 << sb);
      if ($urandom_range(99, 0) < WILD_PCT) begin
         acc.address = $urandom;
      end else begin
         acc.address = ((tag_base + $urandom_range(eff_ways() + 1, 0)) << (sh + sb)) |
                       ($urandom_range(span - 1, 0) << sh) |
                       ($urandom & ((32'd1 << sh) - 1));
      end
      acc.action = 1'($urandom_range(1, 0));
      access_q.push_back(acc);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_OFFSET_SHIFT:   cfg_offset_shift = value;
         CSR_SET_INDEX_BITS: cfg_set_bits     = value;
         CSR_WAYS_IN_USE:    cfg_ways         = value;
         CSR_WRITE_BACK:     cfg_write_back   = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [CFG_W-1:0] shift, logic [CFG_W-1:0] set_bits,
                                 logic [CFG_W-1:0] ways, logic wb);
      write_csr(CSR_OFFSET_SHIFT, shift);
      write_csr(CSR_SET_INDEX_BITS, set_bits);
      write_csr(CSR_WAYS_IN_USE, ways);
      write_csr(CSR_WRITE_BACK, {{(CFG_W-1){1'b0}}, wb});
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic drain();
      while (access_q.size() != 0 || lookup_q.size() != 0 || req_if.valid)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL set_associative_cache_lookup_lru_top");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            lookup_q.push_back(predict_lookup(offered));
            accesses_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (access_q.size() != 0 &&
                ((accesses_sent >= 150 && accesses_sent < 250) ||
                 $urandom_range(99, 0) >= IDLE_PCT)) begin
               offered = access_q.pop_front();
               req_if.valid   <= 1'b1;
               req_if.address <= offered.address;
               req_if.action  <= offered.action;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            lookups_seen++;
            if (rsp_if.hit === 1'b1) hits_seen++;
            if (lookup_q.size() == 0) begin
               $display("%0t: response beat with nothing expected, got hit %0b way %0d",
                        $time, rsp_if.hit, rsp_if.way);
               errors++;
            end else begin
               want = lookup_q.pop_front();
               check_field("hit", {31'd0, want.hit}, {31'd0, rsp_if.hit});
               check_field("way", {29'd0, want.way}, {29'd0, rsp_if.way});
               check_field("total_hits", want.total_hits, rsp_if.total_hits);
               check_field("total_misses", want.total_misses, rsp_if.total_misses);
            end
         end
         if (!stall_done && lookups_seen == STALL_AT) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (lookups_seen >= 150 && lookups_seen < 250) ||
                            $urandom_range(99, 0) >= IDLE_PCT;
         end
      end
   end

   initial begin
      int i;
      int p;
      req_if.valid     = 1'b0;
      req_if.address   = '0;
      req_if.action    = ACT_READ;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CSR_OFFSET_SHIFT;
      csr_if.data      = '0;
      cfg_offset_shift = RST_OFFSET_SHIFT;
      cfg_set_bits     = RST_SET_INDEX_BITS;
      cfg_ways         = RST_WAYS_IN_USE;
      cfg_write_back   = RST_WRITE_BACK;
      hit_total        = '0;
      miss_total       = '0;
      errors           = 0;
      accesses_sent    = 0;
      lookups_seen     = 0;
      hits_seen        = 0;
      settings_used    = 1;
      stall_left       = 0;
      stall_done       = 1'b0;
      for (i = 0; i < ENTRIES; i++) line_age[i] = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: single way, 64-byte lines
      queue_access(32'h0000_0000, ACT_READ);
      queue_access(32'h0000_0000, ACT_WRITE);
      queue_access(32'hFFFF_FFFF, ACT_WRITE);
      queue_access(32'hFFFF_FFC0, ACT_READ);
      queue_access(32'h0000_2000, ACT_READ);
      queue_access(32'h0000_0000, ACT_READ);
      queue_access(32'h5555_5555, ACT_WRITE);
      queue_access(32'hAAAA_AAAA, ACT_READ);
      drain();

      // clamped: shift above max, set bits above max, zero ways
      apply_settings(4'd15, 4'd15, 4'd0, 1'b0);
      queue_access(32'h0000_0000, ACT_WRITE);
      queue_access(32'h0000_01FF, ACT_READ);
      queue_access(32'h8000_0000, ACT_WRITE);
      queue_access(32'h7FFF_FE00, ACT_READ);
      drain();

      // clamped: shift below min, one set, ways above max; fill then evict
      apply_settings(4'd1, 4'd0, 4'd15, 1'b1);
      for (i = 0; i < 10; i++) queue_access(32'(i * 4), i[0] ? ACT_WRITE : ACT_READ);
      queue_access(32'h0000_000C, ACT_READ);
      queue_access(32'h0000_0024, ACT_WRITE);
      queue_access(32'h0000_0050, ACT_READ);
      drain();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(4'd2, 4'd0, 4'd1, 1'b0);
            1: apply_settings(4'd9, 4'd10, 4'd8, 1'b1);
            2: apply_settings(4'd2, 4'd10, 4'd8, 1'b0);
            3: apply_settings(4'd9, 4'd0, 4'd4, 1'b1);
            default: apply_settings(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)),
                                    4'($urandom_range(15, 0)), 1'($urandom_range(1, 0)));
         endcase
         tag_base = $urandom;
         for (i = 0; i < PHASE_BEATS; i++) queue_random_access();
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d accesses (%0d hits, %0d misses) across %0d register settings.",
               lookups_seen, hits_seen, lookups_seen - hits_seen, settings_used);
      if (errors == 0) begin
         $display("PASS set_associative_cache_lookup_lru_top");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL set_associative_cache_lookup_lru_top");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/sacl_pkg.sv
rtl/sacl_ifs.sv
rtl/sacl_way_scan.sv
rtl/set_associative_cache_lookup_lru_top.sv
sim/set_associative_cache_lookup_lru_top_tb.sv
